>>> hw/rtl/button_debounce_long_press_repeat_assert.svh
// ----------------------------------------------------------------------------
// button debounce assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_ASSERT_SVH
`ifndef SYNTHESIS
// generic check, clocked on clk and held off during reset
`define BDLP_CHECK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bdlp check failed");
// check that applies to every result beat on offer
`define BDLP_CHECK_OUT(lbl, cond) \
    `BDLP_CHECK(lbl, out_valid |-> (cond))
`else
`define BDLP_CHECK(lbl, prop)
`define BDLP_CHECK_OUT(lbl, cond)
`endif
`endif

>>> hw/rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared widths, codes, reset values and types of the button debounce block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int CODE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int THR_BITS   = 10;
    localparam int FRAC_BITS  = 14;
    localparam int DELAY_W    = 30;
    localparam int MS_W       = 16;
    localparam int COUNT_W    = 5;
    localparam int LOW_W      = 60;
    localparam int HIGH_W     = 30;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CODE_W-1:0]  CODE_NONE    = '0;
    localparam logic [CODE_W-1:0]  CODE_PRESSED = 8'hFF;
    localparam logic [DELAY_W-1:0] DELAY_MAX    = '1;

    localparam logic               RESET_BOOL_MODE = 1'b1;
    localparam logic [THR_BITS-1:0] RESET_BOOL_THR = 10'd512;
    localparam logic [MS_W-1:0]    RESET_DEBOUNCE  = 16'd50;
    localparam logic [MS_W-1:0]    RESET_FIRST     = 16'd1000;
    localparam logic [MS_W-1:0]    RESET_FLOOR     = 16'd100;
    localparam logic [MS_W-1:0]    RESET_FACTOR    = 16'd12288;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOOL_MODE   = 3'd0,
        CFG_BOOL_THR    = 3'd1,
        CFG_LADDER_LOW  = 3'd2,
        CFG_LADDER_HIGH = 3'd3,
        CFG_DEBOUNCE    = 3'd4,
        CFG_LP_FIRST    = 3'd5,
        CFG_LP_FLOOR    = 3'd6,
        CFG_LP_FACTOR   = 3'd7
    } cfg_idx_e;

    typedef struct packed {
        logic                bool_mode;
        logic [THR_BITS-1:0] bool_threshold;
        logic [HIGH_W-1:0]   ladder_high;
        logic [LOW_W-1:0]    ladder_low;
    } front_cfg_t;

    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] first_ms;
        logic [MS_W-1:0] floor_ms;
        logic [MS_W-1:0] factor;
    } back_cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] now_ms;
    } queue_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hw/rtl/bdlp_front.sv
// ----------------------------------------------------------------------------
// bdlp_front
// takes input beats, classifies the sample to a button code, feeds the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_front
    import bdlp_pkg::*;
#(
    parameter int LADDER_LEVELS = 9,
    parameter int SAMPLE_BITS   = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  front_cfg_t             cfg,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TIME_W-1:0]      now_ms,
    input  queue_status_t          q_status,
    output logic                   q_push,
    output queue_item_t            q_item
);

    localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic                       stage_valid_reg;
    logic                       stage_valid_next;
    queue_item_t                stage_item_reg;
    logic                       accept;
    logic [CMP_W-1:0]           sample_ext;
    logic [HIGH_W+LOW_W-1:0]    all_thr;
    logic [CODE_W-1:0]          code;

    assign sample_ext = CMP_W'(sample);
    assign all_thr    = {cfg.ladder_high, cfg.ladder_low};

    // boolean mode: pressed below the threshold; ladder: first threshold that the sample does not exceed
    always_comb
    begin
        if (cfg.bool_mode)
        begin
            code = (sample_ext >= CMP_W'(cfg.bool_threshold)) ? CODE_NONE : CODE_PRESSED;
        end
        else
        begin
            code = CODE_W'(LADDER_LEVELS);
            for (int i = LADDER_LEVELS - 1; i >= 0; i--)
            begin
                if (sample_ext <= CMP_W'(all_thr[THR_BITS*i +: THR_BITS]))
                begin
                    code = CODE_W'(i);
                end
            end
        end
    end

    assign in_stall = stage_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = stage_valid_reg && !q_status.full;
    assign q_item   = stage_item_reg;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.code   <= code;
            stage_item_reg.now_ms <= now_ms;
        end
    end

endmodule

>>> hw/rtl/bdlp_queue.sv
// ----------------------------------------------------------------------------
// bdlp_queue
// short register queue between the classifier and the state update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_queue
    import bdlp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  queue_item_t   push_item,
    input  logic          pop,
    output queue_item_t   head_item,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/bdlp_back.sv
// ----------------------------------------------------------------------------
// bdlp_back
// debounce and long press state update, one queued beat per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_back
    import bdlp_pkg::*;
#(
    parameter int MAX_REPEATS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  back_cfg_t           cfg,
    input  queue_status_t       q_status,
    input  queue_item_t         q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CODE_W-1:0]   short_code,
    output logic [CODE_W-1:0]   long_code,
    output logic [COUNT_W-1:0]  repeat_count,
    output logic [CODE_W-1:0]   stable_code
);

    localparam int PROD_W = DELAY_W + MS_W;

    logic [CODE_W-1:0]   last_code_reg,      last_code_next;
    logic [TIME_W-1:0]   change_time_reg,    change_time_next;
    logic [CODE_W-1:0]   debounced_code_reg, debounced_code_next;
    logic [TIME_W-1:0]   debounced_time_reg, debounced_time_next;
    logic [COUNT_W-1:0]  long_count_reg,     long_count_next;
    logic [DELAY_W-1:0]  repeat_delay_reg,   repeat_delay_next;
    logic                out_valid_reg,      out_valid_next;
    logic [CODE_W-1:0]   short_code_reg,     short_code_next;
    logic [CODE_W-1:0]   long_code_reg,      long_code_next;
    logic [COUNT_W-1:0]  repeat_count_reg;
    logic [CODE_W-1:0]   stable_code_reg;

    logic [CODE_W-1:0]   code;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   since_change;
    logic [TIME_W-1:0]   since_event;
    logic [MS_W-1:0]     eff_delay;
    logic [PROD_W-1:0]   product;
    logic [TIME_W-1:0]   scaled;
    logic [DELAY_W-1:0]  grown_delay;
    logic                take;

    assign code = q_item.code;
    assign now  = q_item.now_ms;

    // room in the output register, or the waiting beat leaves this cycle
    assign take           = !out_valid_reg || !out_stall;
    assign q_pop          = take && !q_status.empty;
    assign out_valid_next = q_pop || (out_valid_reg && out_stall);

    assign since_change = now - change_time_reg;
    assign since_event  = now - debounced_time_reg;

    always_comb
    begin
        eff_delay = repeat_delay_reg[DELAY_W-1:FRAC_BITS];
        if (eff_delay < cfg.floor_ms)
        begin
            eff_delay = cfg.floor_ms;
        end
    end

    // geometric growth in q2.14, saturated to the delay register range
    assign product     = PROD_W'(repeat_delay_reg) * PROD_W'(cfg.factor);
    assign scaled      = product[FRAC_BITS +: TIME_W];
    assign grown_delay = (|scaled[TIME_W-1:DELAY_W]) ? DELAY_MAX : scaled[DELAY_W-1:0];

    always_comb
    begin
        last_code_next      = last_code_reg;
        change_time_next    = change_time_reg;
        debounced_code_next = debounced_code_reg;
        debounced_time_next = debounced_time_reg;
        long_count_next     = long_count_reg;
        repeat_delay_next   = repeat_delay_reg;
        short_code_next     = CODE_NONE;
        long_code_next      = CODE_NONE;
        if (q_pop)
        begin
            last_code_next = code;
            if (code != last_code_reg)
            begin
                change_time_next = now;
            end
            else if (code != debounced_code_reg)
            begin
                if (since_change > TIME_W'(cfg.debounce_ms))
                begin
                    short_code_next     = (long_count_reg != '0) ? CODE_NONE
                                                                 : debounced_code_reg;
                    debounced_code_next = code;
                    debounced_time_next = now;
                    long_count_next     = '0;
                    repeat_delay_next   = {cfg.first_ms, {FRAC_BITS{1'b0}}};
                end
            end
            else if (debounced_code_reg != CODE_NONE)
            begin
                if (since_event >= TIME_W'(eff_delay))
                begin
                    long_code_next = debounced_code_reg;
                    if (long_count_reg < COUNT_W'(MAX_REPEATS))
                    begin
                        long_count_next   = long_count_reg + 1'b1;
                        repeat_delay_next = grown_delay;
                    end
                    debounced_time_next = now;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg      <= CODE_NONE;
            change_time_reg    <= '0;
            debounced_code_reg <= CODE_NONE;
            debounced_time_reg <= '0;
            long_count_reg     <= '0;
            repeat_delay_reg   <= {RESET_FIRST, {FRAC_BITS{1'b0}}};
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            last_code_reg      <= last_code_next;
            change_time_reg    <= change_time_next;
            debounced_code_reg <= debounced_code_next;
            debounced_time_reg <= debounced_time_next;
            long_count_reg     <= long_count_next;
            repeat_delay_reg   <= repeat_delay_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            short_code_reg   <= short_code_next;
            long_code_reg    <= long_code_next;
            repeat_count_reg <= long_count_next;
            stable_code_reg  <= debounced_code_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign short_code   = short_code_reg;
    assign long_code    = long_code_reg;
    assign repeat_count = repeat_count_reg;
    assign stable_code  = stable_code_reg;

endmodule

>>> hw/rtl/button_debounce_long_press_repeat.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// path from input beat to result beat: classify, queue, update, each one registered
// throughput: 1 beat per cycle while the output is not stalled, set by the state update loop
// reset: state, queue and config cleared to defaults at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_long_press_repeat_assert.svh"

module button_debounce_long_press_repeat
    import bdlp_pkg::*;
#(
    parameter int MAX_REPEATS   = 20,
    parameter int LADDER_LEVELS = 9,
    parameter int SAMPLE_BITS   = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TIME_W-1:0]      now_ms,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CODE_W-1:0]      short_code,
    output logic [CODE_W-1:0]      long_code,
    output logic [COUNT_W-1:0]     repeat_count,
    output logic [CODE_W-1:0]      stable_code
);

    front_cfg_t    front_cfg_reg;
    back_cfg_t     back_cfg_reg;
    queue_status_t q_status;
    queue_item_t   push_item;
    queue_item_t   head_item;
    logic          q_push;
    logic          q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg.bool_mode      <= RESET_BOOL_MODE;
            front_cfg_reg.bool_threshold <= RESET_BOOL_THR;
            front_cfg_reg.ladder_low     <= '0;
            front_cfg_reg.ladder_high    <= '0;
            back_cfg_reg.debounce_ms     <= RESET_DEBOUNCE;
            back_cfg_reg.first_ms        <= RESET_FIRST;
            back_cfg_reg.floor_ms        <= RESET_FLOOR;
            back_cfg_reg.factor          <= RESET_FACTOR;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_e'(cfg_index))
                CFG_BOOL_MODE:   front_cfg_reg.bool_mode      <= cfg_data[0];
                CFG_BOOL_THR:    front_cfg_reg.bool_threshold <= cfg_data[THR_BITS-1:0];
                CFG_LADDER_LOW:  front_cfg_reg.ladder_low     <= cfg_data[LOW_W-1:0];
                CFG_LADDER_HIGH: front_cfg_reg.ladder_high    <= cfg_data[HIGH_W-1:0];
                CFG_DEBOUNCE:    back_cfg_reg.debounce_ms     <= cfg_data[MS_W-1:0];
                CFG_LP_FIRST:    back_cfg_reg.first_ms        <= cfg_data[MS_W-1:0];
                CFG_LP_FLOOR:    back_cfg_reg.floor_ms        <= cfg_data[MS_W-1:0];
                CFG_LP_FACTOR:   back_cfg_reg.factor          <= cfg_data[MS_W-1:0];
                default:         ;
            endcase
        end
    end

    bdlp_front #(
        .LADDER_LEVELS (LADDER_LEVELS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (front_cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .now_ms   (now_ms),
        .q_status (q_status),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    bdlp_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .status    (q_status)
    );

    bdlp_back #(
        .MAX_REPEATS (MAX_REPEATS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (back_cfg_reg),
        .q_status     (q_status),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .short_code   (short_code),
        .long_code    (long_code),
        .repeat_count (repeat_count),
        .stable_code  (stable_code)
    );

    // a fresh result beat only ever follows a cycle with something queued
    `BDLP_CHECK(a_out_from_queue, (out_valid && !$past(out_valid)) |-> $past(!q_status.empty))
    `BDLP_CHECK_OUT(a_count_bound, repeat_count <= COUNT_W'(MAX_REPEATS))
    `BDLP_CHECK_OUT(a_one_event, (short_code == CODE_NONE) || (long_code == CODE_NONE))
    `BDLP_CHECK_OUT(a_short_clears, (short_code == CODE_NONE) || (repeat_count == '0))
    `BDLP_CHECK_OUT(a_long_held, (long_code == CODE_NONE) || (long_code == stable_code))

endmodule

>>> bench/debounce_checker.sv
// ----------------------------------------------------------------------------
// debounce checker
// follows every accepted sample beat with its own debounce and autorepeat
// state, queues the press report it should cause and compares each result
// beat with the oldest queued report, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounce_checker
    import bdlp_pkg::*;
#(
    parameter int MAX_REPEATS   = 20,
    parameter int LADDER_LEVELS = 9,
    parameter int SAMPLE_BITS   = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TIME_W-1:0]      now_ms,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [CODE_W-1:0]      short_code,
    input  logic [CODE_W-1:0]      long_code,
    input  logic [COUNT_W-1:0]     repeat_count,
    input  logic [CODE_W-1:0]      stable_code,
    output int                     reports_due,
    output int                     mismatches
);

    typedef struct packed {
        logic [CODE_W-1:0]  short_c;
        logic [CODE_W-1:0]  long_c;
        logic [COUNT_W-1:0] count;
        logic [CODE_W-1:0]  stable;
    } press_report_t;

    press_report_t press_reports_q[$];
    press_report_t oldest;

    front_cfg_t front;
    back_cfg_t  back;

    logic [CODE_W-1:0]  prev_code;
    logic [TIME_W-1:0]  change_ms;
    logic [CODE_W-1:0]  debounced;
    logic [TIME_W-1:0]  debounced_ms;
    logic [COUNT_W-1:0] press_count;
    logic [TIME_W-1:0]  delay_q;

    task automatic report(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [CODE_W-1:0] classify_sample(input logic [SAMPLE_BITS-1:0] s);
        logic [HIGH_W+LOW_W-1:0] rungs;
        logic [CODE_W-1:0]       code;
        rungs = {front.ladder_high, front.ladder_low};
        if (front.bool_mode)
            return (s >= front.bool_threshold) ? CODE_NONE : CODE_PRESSED;
        code = CODE_W'(LADDER_LEVELS);
        // walk down so that the lowest rung not exceeded wins
        for (int i = LADDER_LEVELS - 1; i >= 0; i--)
        begin
            if (s <= rungs[THR_BITS*i +: THR_BITS])
                code = CODE_W'(i);
        end
        return code;
    endfunction

    task automatic predict_press(input logic [SAMPLE_BITS-1:0] s, input logic [TIME_W-1:0] t);
        press_report_t     rep;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] wait_ms;
        logic [63:0]       grown;
        rep = '0;
        code = classify_sample(s);
        if (code != prev_code)
        begin
            change_ms = t;
        end
        else if (code != debounced)
        begin
            elapsed = t - change_ms;
            if (elapsed > TIME_W'(back.debounce_ms))
            begin
                // a release only counts as a short press if nothing repeated
                rep.short_c  = (press_count != '0) ? CODE_NONE : debounced;
                debounced    = code;
                debounced_ms = t;
                press_count  = '0;
                delay_q      = TIME_W'(back.first_ms) << FRAC_BITS;
            end
        end
        else if (debounced != CODE_NONE)
        begin
            wait_ms = delay_q >> FRAC_BITS;
            if (wait_ms < TIME_W'(back.floor_ms))
                wait_ms = TIME_W'(back.floor_ms);
            elapsed = t - debounced_ms;
            if (elapsed >= wait_ms)
            begin
                rep.long_c = debounced;
                if (press_count < MAX_REPEATS)
                begin
                    grown = (64'(delay_q) * 64'(back.factor)) >> FRAC_BITS;
                    press_count++;
                    delay_q = (grown > 64'(DELAY_MAX)) ? TIME_W'(DELAY_MAX)
                                                       : grown[TIME_W-1:0];
                end
                debounced_ms = t;
            end
        end
        prev_code  = code;
        rep.count  = press_count;
        rep.stable = debounced;
        press_reports_q.push_back(rep);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front.bool_mode      = RESET_BOOL_MODE;
            front.bool_threshold = RESET_BOOL_THR;
            front.ladder_low     = '0;
            front.ladder_high    = '0;
            back.debounce_ms     = RESET_DEBOUNCE;
            back.first_ms        = RESET_FIRST;
            back.floor_ms        = RESET_FLOOR;
            back.factor          = RESET_FACTOR;
            prev_code            = CODE_NONE;
            change_ms            = '0;
            debounced            = CODE_NONE;
            debounced_ms         = '0;
            press_count          = '0;
            delay_q              = TIME_W'(RESET_FIRST) << FRAC_BITS;
            mismatches           = 0;
            press_reports_q.delete();
            reports_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_e'(cfg_index))
                    CFG_BOOL_MODE:   front.bool_mode      = cfg_data[0];
                    CFG_BOOL_THR:    front.bool_threshold = cfg_data[THR_BITS-1:0];
                    CFG_LADDER_LOW:  front.ladder_low     = cfg_data[LOW_W-1:0];
                    CFG_LADDER_HIGH: front.ladder_high    = cfg_data[HIGH_W-1:0];
                    CFG_DEBOUNCE:    back.debounce_ms     = cfg_data[MS_W-1:0];
                    CFG_LP_FIRST:    back.first_ms        = cfg_data[MS_W-1:0];
                    CFG_LP_FLOOR:    back.floor_ms        = cfg_data[MS_W-1:0];
                    CFG_LP_FACTOR:   back.factor          = cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_press(sample, now_ms);
            if (out_valid && !out_stall)
            begin
                if (press_reports_q.size() == 0)
                begin
                    report("result beat with nothing expected");
                end
                else
                begin
                    oldest = press_reports_q.pop_front();
                    if (short_code !== oldest.short_c)
                        report($sformatf("short_code got %0d expected %0d",
                                         short_code, oldest.short_c));
                    if (long_code !== oldest.long_c)
                        report($sformatf("long_code got %0d expected %0d",
                                         long_code, oldest.long_c));
                    if (repeat_count !== oldest.count)
                        report($sformatf("repeat_count got %0d expected %0d",
                                         repeat_count, oldest.count));
                    if (stable_code !== oldest.stable)
                        report($sformatf("stable_code got %0d expected %0d",
                                         stable_code, oldest.stable));
                end
            end
            reports_due <= press_reports_q.size();
        end
    end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// button debounce testbench
// drives sample beats as bounces, holds and releases under several register
// settings, with random input gaps and result side stalls; the checker beside
// the block predicts every press report and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import bdlp_pkg::*;

    localparam int SAMPLE_W       = 10;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
    localparam int RUNGS          = (HIGH_W + LOW_W) / THR_BITS;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int CYCLE_LIMIT    = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample;
    logic [TIME_W-1:0]     now_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [CODE_W-1:0]     short_code;
    logic [CODE_W-1:0]     long_code;
    logic [COUNT_W-1:0]    repeat_count;
    logic [CODE_W-1:0]     stable_code;
    int                    reports_due;
    int                    mismatches;

    front_cfg_t        cur_front;
    logic [TIME_W-1:0] clock_ms;
    int                step_scale;
    int                gap_odds;
    int                beats_sent;
    int                squeezes_asked;
    bit                idle_on;
    int                cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    button_debounce_long_press_repeat u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .short_code   (short_code),
        .long_code    (long_code),
        .repeat_count (repeat_count),
        .stable_code  (stable_code)
    );

    debounce_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .short_code   (short_code),
        .long_code    (long_code),
        .repeat_count (repeat_count),
        .stable_code  (stable_code),
        .reports_due  (reports_due),
        .mismatches   (mismatches)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall bursts, plus the long hold-off when asked
    initial
    begin : receiver
        int squeezes_done;
        squeezes_done = 0;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (squeezes_asked != squeezes_done)
            begin
                squeezes_done++;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
        if (idle_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        now_ms   <= t;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    task automatic step_and_send(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] dt);
        clock_ms += dt;
        send_beat(s, clock_ms);
    endtask

    function automatic logic [TIME_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return $urandom;
        else if (r < 12)
            return $urandom_range(0, 70000);
        return $urandom_range(0, step_scale);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_due != 0);
    endtask

    task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value,
                             input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'({$urandom, $urandom});
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        // bits above the register are junk and must be dropped
        cfg_data  <= (width < CFG_DATA_W) ? ((junk << width) | value) : value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input front_cfg_t f, input back_cfg_t b);
        drain();
        write_reg(CFG_BOOL_MODE,   CFG_DATA_W'(f.bool_mode),      1);
        write_reg(CFG_BOOL_THR,    CFG_DATA_W'(f.bool_threshold), THR_BITS);
        write_reg(CFG_LADDER_LOW,  CFG_DATA_W'(f.ladder_low),     LOW_W);
        write_reg(CFG_LADDER_HIGH, CFG_DATA_W'(f.ladder_high),    HIGH_W);
        write_reg(CFG_DEBOUNCE,    CFG_DATA_W'(b.debounce_ms),    MS_W);
        write_reg(CFG_LP_FIRST,    CFG_DATA_W'(b.first_ms),       MS_W);
        write_reg(CFG_LP_FLOOR,    CFG_DATA_W'(b.floor_ms),       MS_W);
        write_reg(CFG_LP_FACTOR,   CFG_DATA_W'(b.factor),         MS_W);
        cfg_we <= 1'b0;
        cur_front = f;
        step_scale = int'(b.debounce_ms);
        if (int'(b.floor_ms) > step_scale)
            step_scale = int'(b.floor_ms);
        if (int'(b.first_ms) > step_scale)
            step_scale = int'(b.first_ms);
        // a growing delay climbs to its saturated value, so take long steps
        if (int'(b.factor) > 16384)
            step_scale = 70000;
        step_scale += 1;
    endtask

    task automatic ascending_ladder(output logic [LOW_W-1:0] low,
                                    output logic [HIGH_W-1:0] high);
        logic [HIGH_W+LOW_W-1:0] rungs;
        int level;
        level = $urandom_range(0, 60);
        for (int i = 0; i < RUNGS; i++)
        begin
            rungs[THR_BITS*i +: THR_BITS] = THR_BITS'(level);
            level += $urandom_range(0, 160);
            if (level > SAMPLE_MAX)
                level = SAMPLE_MAX;
        end
        {high, low} = rungs;
    endtask

    // bounce, then hold one sample long enough to debounce and repeat
    task automatic press_sequence();
        logic [HIGH_W+LOW_W-1:0] rungs;
        logic [SAMPLE_W-1:0]     held;
        int                      hold_len;
        int                      level;
        rungs = {cur_front.ladder_high, cur_front.ladder_low};
        held = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        if ($urandom_range(0, 2) == 0)
        begin
            if (cur_front.bool_mode)
            begin
                held = SAMPLE_W'($urandom_range(int'(cur_front.bool_threshold), SAMPLE_MAX));
            end
            else
            begin
                // sit on or just above a rung
                level = int'(rungs[THR_BITS*$urandom_range(0, RUNGS - 1) +: THR_BITS]);
                level += $urandom_range(0, 1);
                held = (level > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(level);
            end
        end
        gap_odds = $urandom_range(0, 2) * 4;
        repeat ($urandom_range(0, 4))
            step_and_send(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                          TIME_W'($urandom_range(0, step_scale / 4)));
        hold_len = $urandom_range(3, 45);
        repeat (hold_len)
        begin
            if ($urandom_range(0, 24) == 0)
                step_and_send(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), pick_step());
            else
                step_and_send(held, pick_step());
        end
    endtask

    task automatic noise_burst();
        gap_odds = 4;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 1) == 0)
                clock_ms = $urandom;
            else
                clock_ms += pick_step();
            send_beat(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), clock_ms);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
                noise_burst();
            else
                press_sequence();
        end
    endtask

    initial
    begin
        front_cfg_t f;
        back_cfg_t  b;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_BOOL_MODE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        sample         = '0;
        now_ms         = '0;
        idle_on        = 1'b1;
        gap_odds       = 4;
        beats_sent     = 0;
        squeezes_asked = 0;
        step_scale     = int'(RESET_FIRST) + 1;
        cur_front.bool_mode      = RESET_BOOL_MODE;
        cur_front.bool_threshold = RESET_BOOL_THR;
        cur_front.ladder_low     = '0;
        cur_front.ladder_high    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: threshold edge, debounce edge, first repeat, reload,
        // release after repeats, plain short press, time wrapping round
        send_beat(10'd1023, 32'd0);
        send_beat(10'd0,    32'd5);
        send_beat(10'd0,    32'd55);
        send_beat(10'd511,  32'd56);
        send_beat(10'd0,    32'd1055);
        send_beat(10'd0,    32'd1056);
        send_beat(10'd0,    32'd1806);
        send_beat(10'd512,  32'd1810);
        send_beat(10'd1023, 32'd1861);
        send_beat(10'd100,  32'd1900);
        send_beat(10'd200,  32'd1951);
        send_beat(10'd513,  32'd2000);
        send_beat(10'd513,  32'd2051);
        send_beat(10'd0,    32'hFFFF_FFC0);
        send_beat(10'd0,    32'h0000_0000);
        send_beat(10'd0,    32'hFFFF_FFFF);
        send_beat(10'd1023, 32'hFFFF_FFFF);
        send_beat(10'd1023, 32'h0000_0033);
        clock_ms = 32'h0000_0033;

        // boolean button at the usual timings; the receiver holds off early on
        f.bool_mode      = 1'b1;
        f.bool_threshold = THR_BITS'($urandom_range(1, SAMPLE_MAX - 1));
        f.ladder_low     = LOW_W'({$urandom, $urandom});
        f.ladder_high    = HIGH_W'($urandom);
        b.debounce_ms    = RESET_DEBOUNCE;
        b.first_ms       = RESET_FIRST;
        b.floor_ms       = RESET_FLOOR;
        b.factor         = RESET_FACTOR;
        apply_settings(f, b);
        squeezes_asked++;
        run_random(180);

        // ascending ladder, delay halving
        f.bool_mode      = 1'b0;
        f.bool_threshold = THR_BITS'($urandom_range(0, SAMPLE_MAX));
        ascending_ladder(f.ladder_low, f.ladder_high);
        b.debounce_ms    = MS_W'($urandom_range(0, 100));
        b.first_ms       = MS_W'($urandom_range(200, 2000));
        b.floor_ms       = MS_W'($urandom_range(10, 200));
        b.factor         = 16'd8192;
        apply_settings(f, b);
        run_random(180);

        // unordered ladder, anything goes
        f.bool_threshold = THR_BITS'($urandom_range(0, SAMPLE_MAX));
        f.ladder_low     = LOW_W'({$urandom, $urandom});
        f.ladder_high    = HIGH_W'($urandom);
        b.debounce_ms    = MS_W'($urandom_range(0, 300));
        b.first_ms       = MS_W'($urandom_range(0, 3000));
        b.floor_ms       = MS_W'($urandom_range(0, 300));
        b.factor         = MS_W'($urandom);
        apply_settings(f, b);
        run_random(150);

        // every register at its lowest
        f.bool_mode      = 1'b0;
        f.bool_threshold = '0;
        f.ladder_low     = '0;
        f.ladder_high    = '0;
        b.debounce_ms    = '0;
        b.first_ms       = '0;
        b.floor_ms       = '0;
        b.factor         = '0;
        apply_settings(f, b);
        run_random(120);

        // every register at its highest
        f.bool_mode      = 1'b1;
        f.bool_threshold = '1;
        f.ladder_low     = '1;
        f.ladder_high    = '1;
        b.debounce_ms    = '1;
        b.first_ms       = '1;
        b.floor_ms       = '1;
        b.factor         = '1;
        apply_settings(f, b);
        run_random(120);

        // delay growing into saturation
        f.bool_mode      = 1'b0;
        f.bool_threshold = THR_BITS'($urandom_range(0, SAMPLE_MAX));
        ascending_ladder(f.ladder_low, f.ladder_high);
        b.debounce_ms    = '0;
        b.first_ms       = MS_W'($urandom_range(1, 4000));
        b.floor_ms       = '0;
        b.factor         = '1;
        apply_settings(f, b);
        run_random(150);

        // back to back beats with no idling on either side
        f.bool_mode      = 1'($urandom_range(0, 1));
        f.bool_threshold = THR_BITS'($urandom_range(0, SAMPLE_MAX));
        ascending_ladder(f.ladder_low, f.ladder_high);
        b.debounce_ms    = MS_W'($urandom_range(0, 200));
        b.first_ms       = MS_W'($urandom_range(0, 2000));
        b.floor_ms       = MS_W'($urandom_range(0, 500));
        b.factor         = MS_W'($urandom_range(4096, 20000));
        apply_settings(f, b);
        idle_on = 1'b0;
        run_random(200);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bdlp_pkg.sv
hw/rtl/bdlp_front.sv
hw/rtl/bdlp_queue.sv
hw/rtl/bdlp_back.sv
hw/rtl/button_debounce_long_press_repeat.sv
bench/debounce_checker.sv
bench/testbench.sv
